FILE: sv/btn_pc_pkg.sv
// shared types, codes and reset values for the button press classifier
`default_nettype none
package btn_pc_pkg;

   // widths
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_BITS          = 32;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int LIMIT_BITS        = 32;

   typedef logic [1:0]                press_event_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [LIMIT_BITS-1:0]     limit_type;

   // event codes
   localparam press_event_type EV_NONE  = 2'd0;
   localparam press_event_type EV_SHORT = 2'd1;
   localparam press_event_type EV_LONG3 = 2'd2;
   localparam press_event_type EV_LONG8 = 2'd3;

   // register indexes
   localparam csr_index_type CSR_ENABLED          = 3'd0;
   localparam csr_index_type CSR_ACTIVE_LOW       = 3'd1;
   localparam csr_index_type CSR_DEBOUNCE_TIME    = 3'd2;
   localparam csr_index_type CSR_SHORT_LIMIT      = 3'd3;
   localparam csr_index_type CSR_MEDIUM_THRESHOLD = 3'd4;
   localparam csr_index_type CSR_LONG_THRESHOLD   = 3'd5;

   // register reset values
   localparam logic      ENABLED_RESET          = 1'b1;
   localparam logic      ACTIVE_LOW_RESET       = 1'b1;
   localparam limit_type DEBOUNCE_TIME_RESET    = 32'd50;
   localparam limit_type SHORT_LIMIT_RESET      = 32'd1000;
   localparam limit_type MEDIUM_THRESHOLD_RESET = 32'd3000;
   localparam limit_type LONG_THRESHOLD_RESET   = 32'd8000;

   // idle level of the pin with pull-up wiring
   localparam logic PREVIOUS_RAW_RESET = 1'b1;

   // threshold set handed to the classifier
   typedef struct packed {
      limit_type short_limit;
      limit_type medium_threshold;
      limit_type long_threshold;
   } limits_type;

endpackage
`default_nettype wire

FILE: sv/button_debounce_press_classifier.sv
// debounced button with short / long press classification, top level
// path: an accepted item passes the input register, then the result register, which drives rsp_valid
// throughput: one item per cycle when not stalled by rsp_ready; debounce and press state
// updates in the same cycle the item leaves the input register; the next item sees it at once
// reset: synchronous active-high; registers take their documented defaults,
// previous raw level resets to the pull-up idle level, both stages empty
`default_nettype none
module button_debounce_press_classifier #(
   parameter int TIME_BITS = btn_pc_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // poll items
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_raw_level,
   input  wire logic [btn_pc_pkg::NOW_BITS-1:0]     req_now_time,
   // results
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output btn_pc_pkg::press_event_type              rsp_press_event,
   // configuration writes
   input  wire logic                                csr_write_enable,
   input  wire btn_pc_pkg::csr_index_type           csr_index,
   input  wire logic [btn_pc_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   localparam int CMP_BITS = (TIME_BITS > btn_pc_pkg::LIMIT_BITS) ?
                             TIME_BITS : btn_pc_pkg::LIMIT_BITS;

   // configuration registers
   logic                  enabled_ff;
   logic                  active_low_ff;
   btn_pc_pkg::limit_type debounce_time_ff;
   btn_pc_pkg::limits_type limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff                 <= btn_pc_pkg::ENABLED_RESET;
         active_low_ff              <= btn_pc_pkg::ACTIVE_LOW_RESET;
         debounce_time_ff           <= btn_pc_pkg::DEBOUNCE_TIME_RESET;
         limits_ff.short_limit      <= btn_pc_pkg::SHORT_LIMIT_RESET;
         limits_ff.medium_threshold <= btn_pc_pkg::MEDIUM_THRESHOLD_RESET;
         limits_ff.long_threshold   <= btn_pc_pkg::LONG_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            btn_pc_pkg::CSR_ENABLED: begin
               enabled_ff <= csr_write_data[0];
            end
            btn_pc_pkg::CSR_ACTIVE_LOW: begin
               active_low_ff <= csr_write_data[0];
            end
            btn_pc_pkg::CSR_DEBOUNCE_TIME: begin
               debounce_time_ff <= btn_pc_pkg::LIMIT_BITS'(csr_write_data);
            end
            btn_pc_pkg::CSR_SHORT_LIMIT: begin
               limits_ff.short_limit <= btn_pc_pkg::LIMIT_BITS'(csr_write_data);
            end
            btn_pc_pkg::CSR_MEDIUM_THRESHOLD: begin
               limits_ff.medium_threshold <= btn_pc_pkg::LIMIT_BITS'(csr_write_data);
            end
            btn_pc_pkg::CSR_LONG_THRESHOLD: begin
               limits_ff.long_threshold <= btn_pc_pkg::LIMIT_BITS'(csr_write_data);
            end
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // handshake: input stage moves on when the result register is free or draining
   logic in_valid_ff;
   logic out_free;
   logic stage_fire;

   assign out_free   = !rsp_valid || rsp_ready;
   assign stage_fire = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;

   // input register, payload carries no reset
   logic                 level_ff;
   logic [TIME_BITS-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         level_ff <= req_raw_level;
         now_ff   <= TIME_BITS'(req_now_time);
      end
   end

   // debounce and press tracking state
   logic                 previous_raw_ff, previous_raw_in;
   logic [TIME_BITS-1:0] change_time_ff,  change_time_in;
   logic                 held_ff,         held_in;
   logic                 armed_ff,        armed_in;
   logic [TIME_BITS-1:0] press_begin_ff,  press_begin_in;

   logic                 level_changed;
   logic [TIME_BITS-1:0] stable_for;
   logic                 level_stable;
   logic                 pressed;
   logic [TIME_BITS-1:0] held_for;
   btn_pc_pkg::press_event_type class_event;
   btn_pc_pkg::press_event_type event_in;

   // a fresh edge restarts the stability window at zero
   assign level_changed = level_ff != previous_raw_ff;
   assign stable_for    = level_changed ? '0 : (now_ff - change_time_ff);
   assign level_stable  = CMP_BITS'(stable_for) >= CMP_BITS'(debounce_time_ff);
   assign pressed       = active_low_ff ? !level_ff : level_ff;
   // modulo wrap comes for free from the fixed width
   assign held_for      = now_ff - press_begin_ff;

   btn_pc_classify #(
      .TIME_BITS (TIME_BITS)
   ) u_classify (
      .duration    (held_for),
      .limits      (limits_ff),
      .press_event (class_event)
   );

   always_comb begin
      previous_raw_in = previous_raw_ff;
      change_time_in  = change_time_ff;
      held_in         = held_ff;
      armed_in        = armed_ff;
      press_begin_in  = press_begin_ff;
      event_in        = btn_pc_pkg::EV_NONE;

      // disabled: result none, state frozen
      if (enabled_ff) begin
         if (level_changed) begin
            previous_raw_in = level_ff;
            change_time_in  = now_ff;
         end
         if (level_stable) begin
            if (pressed && !held_ff) begin
               // press start
               held_in        = 1'b1;
               armed_in       = 1'b1;
               press_begin_in = now_ff;
            end else if (!pressed && held_ff) begin
               // release, classify only when armed
               held_in = 1'b0;
               if (armed_ff) begin
                  armed_in = 1'b0;
                  event_in = class_event;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= btn_pc_pkg::PREVIOUS_RAW_RESET;
         change_time_ff  <= '0;
         held_ff         <= 1'b0;
         armed_ff        <= 1'b0;
         press_begin_ff  <= '0;
      end else if (stage_fire) begin
         previous_raw_ff <= previous_raw_in;
         change_time_ff  <= change_time_in;
         held_ff         <= held_in;
         armed_ff        <= armed_in;
         press_begin_ff  <= press_begin_in;
      end
   end

   // result register
   logic                        rsp_valid_ff;
   btn_pc_pkg::press_event_type rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_event_ff <= event_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = rsp_event_ff;

endmodule
`default_nettype wire

FILE: sv/btn_pc_classify.sv
// duration classifier: long8, long3, short or none, first match wins
`default_nettype none
module btn_pc_classify #(
   parameter int TIME_BITS = btn_pc_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic [TIME_BITS-1:0]        duration,
   input  wire btn_pc_pkg::limits_type      limits,
   output btn_pc_pkg::press_event_type      press_event
);

   localparam int CMP_BITS = (TIME_BITS > btn_pc_pkg::LIMIT_BITS) ?
                             TIME_BITS : btn_pc_pkg::LIMIT_BITS;

   logic [CMP_BITS-1:0] dur_wide;
   logic [CMP_BITS-1:0] short_wide;
   logic [CMP_BITS-1:0] medium_wide;
   logic [CMP_BITS-1:0] long_wide;

   assign dur_wide    = CMP_BITS'(duration);
   assign short_wide  = CMP_BITS'(limits.short_limit);
   assign medium_wide = CMP_BITS'(limits.medium_threshold);
   assign long_wide   = CMP_BITS'(limits.long_threshold);

   always_comb begin
      if (dur_wide >= long_wide) begin
         press_event = btn_pc_pkg::EV_LONG8;
      end else if (dur_wide >= medium_wide) begin
         press_event = btn_pc_pkg::EV_LONG3;
      end else if (dur_wide <= short_wide) begin
         press_event = btn_pc_pkg::EV_SHORT;
      end else begin
         press_event = btn_pc_pkg::EV_NONE;
      end
   end

endmodule
`default_nettype wire
